@@ src/fta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_pkg: shared types and constants of the frame timestamp aligner
// Register indexes, sequencer states and fixed time constants.
// ----------------------------------------------------------------------------
package fta_pkg;

  localparam logic [0:0] REG_TRIGGER_ENABLE  = 1'd0;
  localparam logic [0:0] REG_MIN_BASELINE_NS = 1'd1;

  localparam logic [39:0] MIN_BASELINE_RESET = 40'd5000000000;
  localparam logic [29:0] NS_PER_S           = 30'd1000000000;
  localparam logic [19:0] NS_PER_MS          = 20'd1000000;
  localparam logic [3:0]  PTP_MASTER         = 4'd5;
  localparam logic [3:0]  PTP_SLAVE          = 4'd8;
  localparam int unsigned QUEUE_WIDTH        = 256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRIG,
    ST_HOST,
    ST_CAL_MUL,
    ST_CAL_DIV,
    ST_CAL_END,
    ST_CONV_MUL,
    ST_CONV_DIV,
    ST_CONV_END,
    ST_FRAME_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic         start;
    logic [127:0] dividend;
    logic [63:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] quotient;
  } div_rsp_t;

endpackage

@@ src/frame_timestamp_aligner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_timestamp_aligner: trigger queue and frame exposure stamping
// Queues triggers in a RAM and stamps frames with calibrated exposure times.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     start & !busy          mode .. tick_rate_hz
//  config    cfg_valid & cfg_ready  cfg_index, cfg_data
//  result    done (one cycle)       accepted .. match_after_ns
//
//  A trigger passes TRIG and DONE. A frame passes HOST, with CAL_MUL, CAL_DIV,
//  CAL_END and HOST again when it calibrates and CONV_MUL, CONV_DIV, CONV_END
//  when it converts, then FRAME_READ and DONE; the serial divider stalls the
//  DIV states. Reset is synchronous; queue entries need no clearing. The
//  receiver cannot stall: done is one cycle wide and busy stays high until it.
// ----------------------------------------------------------------------------
module frame_timestamp_aligner #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic               command_ok,
  input  logic [63:0]        app_issue_ns,
  input  logic [63:0]        drv_before_ns,
  input  logic [63:0]        drv_after_ns,
  input  logic [63:0]        device_ticks,
  input  logic [43:0]        host_ms,
  input  logic [3:0]         sync_state,
  input  logic [31:0]        tick_rate_hz,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [39:0]        cfg_data,
  output logic               done,
  output logic               accepted,
  output logic [63:0]        trig_seq,
  output logic               matched,
  output logic               sync_locked,
  output logic               time_valid,
  output logic [63:0]        expose_ns,
  output logic signed [63:0] ctrl_delta_ns,
  output logic signed [63:0] drv_delta_ns,
  output logic [63:0]        match_issue_ns,
  output logic [63:0]        match_before_ns,
  output logic [63:0]        match_after_ns
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

  fta_pkg::state_t state, state_next;

  logic        trigger_enable;
  logic [39:0] min_baseline_ns;
  logic [63:0] base_ticks, ref_host_ns, cal_rate, next_seq;
  logic        is_calibrated;
  logic [AW-1:0] queue_head, queue_tail;
  logic [CW-1:0] queue_count;

  logic        i_mode, i_ok, i_locked, i_usable;
  logic [63:0] i_issue, i_before, i_after, i_ticks;
  logic [63:0] host_ns, dt, mag;
  logic [61:0] pp_hi, pp_lo;
  logic        neg;

  logic        ram_we;
  logic [255:0] ram_wdata, ram_rdata;

  fta_pkg::div_req_t div_req;
  fta_pkg::div_rsp_t div_rsp;

  logic        do_cal;
  logic [63:0] exp_val;
  logic        exp_ok;

  assign busy      = (state != fta_pkg::ST_IDLE);
  assign cfg_ready = !busy;

  fta_ram #(.WIDTH(fta_pkg::QUEUE_WIDTH), .DEPTH(1 << AW)) u_queue (
    .clk  (clk),
    .we   (ram_we),
    .waddr(queue_tail),
    .wdata(ram_wdata),
    .raddr(queue_head),
    .rdata(ram_rdata)
  );

  fta_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  always_comb begin
    ram_we    = (state == fta_pkg::ST_TRIG) && trigger_enable && i_ok &&
                (queue_count < FULL);
    ram_wdata = {next_seq, i_issue, i_before, i_after};
    dt        = 64'(i_ticks - base_ticks);
    neg       = dt[63];
    mag       = neg ? 64'(-dt) : dt;
    do_cal    = i_usable && !is_calibrated && (base_ticks != '0) &&
                ($signed(64'(host_ns - ref_host_ns)) > $signed({24'd0, min_baseline_ns}));
  end

  always_comb begin
    div_req.start    = (state == fta_pkg::ST_CAL_MUL) || (state == fta_pkg::ST_CONV_MUL);
    div_req.dividend = {34'd0, {pp_hi, 32'd0} + {32'd0, pp_lo}};
    div_req.divisor  = (state == fta_pkg::ST_CAL_MUL) ? 64'(host_ns - ref_host_ns) : cal_rate;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fta_pkg::ST_IDLE: begin
        if (start) begin
          state_next = mode ? fta_pkg::ST_HOST : fta_pkg::ST_TRIG;
        end
      end
      fta_pkg::ST_TRIG:     state_next = fta_pkg::ST_DONE;
      fta_pkg::ST_HOST: begin
        state_next = do_cal ? fta_pkg::ST_CAL_MUL : fta_pkg::ST_CONV_MUL;
        if (!do_cal && !(i_usable && is_calibrated && cal_rate != '0) &&
            !(i_usable && !is_calibrated && base_ticks == '0)) begin
          state_next = fta_pkg::ST_FRAME_READ;
        end else if (!do_cal && !is_calibrated) begin
          state_next = fta_pkg::ST_FRAME_READ;
        end
      end
      fta_pkg::ST_CAL_MUL:  state_next = fta_pkg::ST_CAL_DIV;
      fta_pkg::ST_CAL_DIV:  state_next = div_rsp.done ? fta_pkg::ST_CAL_END : state;
      fta_pkg::ST_CAL_END:  state_next = fta_pkg::ST_HOST;
      fta_pkg::ST_CONV_MUL: state_next = fta_pkg::ST_CONV_DIV;
      fta_pkg::ST_CONV_DIV: state_next = div_rsp.done ? fta_pkg::ST_CONV_END : state;
      fta_pkg::ST_CONV_END: state_next = fta_pkg::ST_FRAME_READ;
      fta_pkg::ST_FRAME_READ: state_next = fta_pkg::ST_DONE;
      fta_pkg::ST_DONE:     state_next = fta_pkg::ST_IDLE;
      default:              state_next = fta_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= fta_pkg::ST_IDLE;
      trigger_enable  <= 1'b1;
      min_baseline_ns <= fta_pkg::MIN_BASELINE_RESET;
      base_ticks      <= '0;
      ref_host_ns     <= '0;
      cal_rate        <= '0;
      is_calibrated   <= 1'b0;
      next_seq        <= 64'd1;
      queue_head      <= '0;
      queue_tail      <= '0;
      queue_count     <= '0;
      done            <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          fta_pkg::REG_TRIGGER_ENABLE:  trigger_enable  <= cfg_data[0];
          fta_pkg::REG_MIN_BASELINE_NS: min_baseline_ns <= cfg_data;
          default: ;
        endcase
      end
      if (ram_we) begin
        queue_tail  <= (queue_tail == LAST) ? '0 : AW'(queue_tail + 1'b1);
        queue_count <= CW'(queue_count + 1'b1);
        next_seq    <= 64'(next_seq + 64'd1);
      end
      if (state == fta_pkg::ST_HOST && i_usable && !is_calibrated && base_ticks == '0) begin
        base_ticks  <= i_ticks;
        ref_host_ns <= host_ns;
      end
      if (state == fta_pkg::ST_CAL_END) begin
        is_calibrated <= 1'b1;
        if (neg && div_rsp.quotient != '0) begin
          cal_rate <= '0;
        end else if (div_rsp.quotient[127:64] != '0) begin
          cal_rate <= '1;
        end else begin
          cal_rate <= div_rsp.quotient[63:0];
        end
      end
      if (state == fta_pkg::ST_FRAME_READ && queue_count != '0) begin
        queue_head  <= (queue_head == LAST) ? '0 : AW'(queue_head + 1'b1);
        queue_count <= CW'(queue_count - 1'b1);
      end
      if (state == fta_pkg::ST_DONE) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == fta_pkg::ST_IDLE) begin
      i_mode    <= mode;
      i_ok      <= command_ok;
      i_issue   <= app_issue_ns;
      i_before  <= drv_before_ns;
      i_after   <= drv_after_ns;
      i_ticks   <= device_ticks;
      host_ns   <= 64'({20'd0, host_ms} * fta_pkg::NS_PER_MS);
      i_locked  <= (sync_state == fta_pkg::PTP_MASTER) || (sync_state == fta_pkg::PTP_SLAVE);
      i_usable  <= ((sync_state == fta_pkg::PTP_MASTER) || (sync_state == fta_pkg::PTP_SLAVE))
                   && (tick_rate_hz != '0) && (device_ticks != '0);
      exp_ok    <= 1'b0;
      exp_val   <= '0;
    end
    if (state == fta_pkg::ST_HOST) begin
      pp_lo <= {30'd0, mag[31:0]} * {32'd0, fta_pkg::NS_PER_S};
      pp_hi <= {30'd0, mag[63:32]} * {32'd0, fta_pkg::NS_PER_S};
    end
    if (state == fta_pkg::ST_CONV_END) begin
      exp_ok  <= 1'b1;
      exp_val <= 64'(ref_host_ns + (neg ? 64'(-div_rsp.quotient[63:0])
                                        : div_rsp.quotient[63:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (state == fta_pkg::ST_TRIG) begin
      accepted        <= ram_we;
      trig_seq        <= ram_we ? next_seq : '0;
      matched         <= 1'b0;
      sync_locked     <= 1'b0;
      time_valid      <= 1'b0;
      expose_ns       <= '0;
      ctrl_delta_ns   <= '0;
      drv_delta_ns    <= '0;
      match_issue_ns  <= trigger_enable ? i_issue : '0;
      match_before_ns <= trigger_enable ? i_before : '0;
      match_after_ns  <= trigger_enable ? i_after : '0;
    end else if (state == fta_pkg::ST_FRAME_READ) begin
      accepted    <= 1'b0;
      sync_locked <= i_locked;
      time_valid  <= exp_ok;
      expose_ns   <= exp_val;
      matched     <= (queue_count != '0);
    end else if (state == fta_pkg::ST_DONE && i_mode) begin
      trig_seq        <= matched ? ram_rdata[255:192] : '0;
      match_issue_ns  <= matched ? ram_rdata[191:128] : '0;
      match_before_ns <= matched ? ram_rdata[127:64] : '0;
      match_after_ns  <= matched ? ram_rdata[63:0] : '0;
      ctrl_delta_ns   <= (matched && time_valid) ? 64'(expose_ns - ram_rdata[191:128]) : '0;
      drv_delta_ns    <= (matched && time_valid) ? 64'(expose_ns - ram_rdata[127:64]) : '0;
    end
  end

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    queue_count <= FULL)
    else $error("queue count overflow");
  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> queue_count != FULL)
    else $error("write into full queue");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == fta_pkg::ST_IDLE)
    else $error("result while busy");
`endif

endmodule

@@ src/fta_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_ram: generic simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/fta_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_div: radix-2 128 by 64 unsigned divider
// Restoring shift and subtract, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fta_div (
  input  logic              clk,
  input  logic              rst,
  input  fta_pkg::div_req_t req,
  output fta_pkg::div_rsp_t rsp
);

  logic [127:0] quo;
  logic [63:0]  rem;
  logic [63:0]  dvs;
  logic [7:0]   cnt;
  logic         run;
  logic         fin;
  logic [64:0]  shifted;
  logic         take;
  logic [63:0]  rem_next;

  always_comb begin
    shifted  = {rem, quo[127]};
    take     = (shifted >= {1'b0, dvs});
    rem_next = take ? 64'(shifted - {1'b0, dvs}) : shifted[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= 8'(cnt + 8'd1);
        if (cnt == 8'd127) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (run) begin
      quo <= {quo[126:0], take};
      rem <= rem_next;
    end
  end

  assign rsp = '{done: fin, quotient: quo};

`ifndef SYNTHESIS
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> $past(run))
    else $error("divider finished while idle");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |=> run)
    else $error("divider did not start");
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    !run && !$past(req.start) |-> !rsp.done || $past(run))
    else $error("done without run");
`endif

endmodule
